// ===== sv/nepc_pkg.sv =====
// Shared types and constants for the neighbor-equal pixel counter.
// No dependencies; every other file of the block imports this package.
package nepc_pkg;

	localparam int PIX_W     = 8;   // grayscale pixel
	localparam int CNT_W     = 28;  // frame total
	localparam int CFG_W     = 13;  // frame_width / frame_height registers
	localparam int ROW_W     = 12;  // row position
	localparam int CFG_IDX_W = 2;   // configuration register index
	localparam int ADD_W     = 4;   // per-pixel increment, at most 9

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(480);
	localparam logic [CFG_W-1:0] HEIGHT_LIMIT       = CFG_W'(4096);

	// Neighborhood validity of one pixel, decided when the pixel is taken.
	typedef struct packed {
		logic has_left;      // column above zero
		logic has_up;        // row above zero
		logic has_upright;   // row above zero and a column to the right
		logic last;          // last pixel of the frame
	} nepc_flags_t;

endpackage

// ===== sv/nepc_if.sv =====
// Valid/ready channel interfaces: pixel stream, count result, config writes.
// Depends on nepc_pkg for field widths.
interface nepc_pixel_if import nepc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface nepc_count_if import nepc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] match_count;

	modport source (output valid, output match_count, input ready);
	modport sink   (input valid, input match_count, output ready);
endinterface

interface nepc_cfg_if import nepc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/neighbor_equal_pixel_counter.sv =====
// Neighbor-equal pixel counter: frame total of equal 3x3 neighbors over nonzero pixels.
// Throughput: one pixel per clock; a last pixel holds the input only while the previous
// frame total still waits downstream. The row store takes one read pair and one write per pixel.
// Output: the frame total is registered when the last pixel leaves the compare stage.
// Reset: position, window and total clear at once; width 640, height 480; no clearing pass.
// Depends on nepc_pkg, nepc_if, nepc_line_mem, nepc_pos_ctrl and nepc_accum.
module neighbor_equal_pixel_counter import nepc_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	nepc_cfg_if.sink     cfg,
	nepc_pixel_if.sink   pixels,
	nepc_count_if.source counts
);

	localparam int AW = $clog2(MAX_WIDTH);

	// A request is taken when the compare stage is free or drains this cycle.
	logic             take;
	logic             take_ok;
	logic [AW-1:0]    addr_up, addr_upright;
	nepc_flags_t      flags;
	logic [PIX_W-1:0] rd_up, rd_upright;

	assign pixels.ready = take_ok;
	assign take         = pixels.valid && take_ok;

	// Position and geometry: decide the neighborhood of the pixel being taken
	// and point the row store at the columns above and above-right.
	nepc_pos_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.take         (take),
		.addr_up      (addr_up),
		.addr_upright (addr_upright),
		.flags        (flags)
	);

	// Row store: the entry at the current column holds the pixel above until
	// this pixel replaces it. Read and write happen on the same edge, the
	// read seeing the old value, so an earlier pixel's write is always
	// visible to a later read and no bypass is needed, even for one-pixel rows.
	nepc_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk       (clk),
		.en        (take),
		.addr_a    (addr_up),
		.addr_b    (addr_upright),
		.wr_data   (pixels.pixel),
		.rd_data_a (rd_up),
		.rd_data_b (rd_upright)
	);

	// Compare stage: the read data lines up with the registered pixel; the
	// left and up-left neighbors come from the window registers. The frame
	// total goes to the output register on the last pixel, and the stage
	// holds only while a finished total is still waiting downstream.
	nepc_accum u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.pixel      (pixels.pixel),
		.flags      (flags),
		.rd_up      (rd_up),
		.rd_upright (rd_upright),
		.take_ok    (take_ok),
		.result     (counts)
	);

	// The last pixel of a frame returns the position to the top-left corner.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		take && flags.last |=> !flags.has_left && !flags.has_up)
		else $error("position did not wrap after the last pixel of a frame");

	// Without a taken pixel the position holds.
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(addr_up) && $stable(flags.has_up))
		else $error("position moved without a taken pixel");

	// A total left waiting downstream blocks new pixels only behind a last pixel.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> counts.valid && !counts.ready)
		else $error("pixel input stalled without a pending total");

endmodule

// ===== sv/nepc_line_mem.sv =====
// Row store: one write port and two registered read ports.
// Depends on nepc_pkg for the pixel width.
module nepc_line_mem import nepc_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    addr_a,
	input  logic [AW-1:0]    addr_b,
	input  logic [PIX_W-1:0] wr_data,
	output logic [PIX_W-1:0] rd_data_a,
	output logic [PIX_W-1:0] rd_data_b
);

	logic [PIX_W-1:0] mem [DEPTH];

	// Port A reads and writes the same entry: the read returns the old value.
	always_ff @(posedge clk) begin
		if (en) begin
			rd_data_a <= mem[addr_a];
			rd_data_b <= mem[addr_b];
			mem[addr_a] <= wr_data;
		end
	end

endmodule

// ===== sv/nepc_pos_ctrl.sv =====
// Frame geometry registers and raster position tracking.
// Depends on nepc_pkg and nepc_cfg_if.
module nepc_pos_ctrl import nepc_pkg::*; #(
	parameter int MAX_WIDTH = 4096,
	parameter int AW        = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	nepc_cfg_if.sink      cfg,
	input  logic          take,
	output logic [AW-1:0] addr_up,
	output logic [AW-1:0] addr_upright,
	output nepc_flags_t   flags
);

	localparam int EW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

	logic [CFG_W-1:0] width_q, height_q;
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [EW-1:0]    width_ext, width_eff, col_next;
	logic [CFG_W-1:0] height_eff, row_next;
	logic             row_end, frame_end;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RESET;
			height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_FRAME_WIDTH) begin
				width_q <= cfg.data;
			end
			if (cfg.index == REG_FRAME_HEIGHT) begin
				height_q <= cfg.data;
			end
		end
	end

	always_comb begin
		width_ext = EW'(width_q);
		if (width_q == '0) begin
			width_eff = EW'(1);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			width_eff = EW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end

		if (height_q == '0) begin
			height_eff = CFG_W'(1);
		end else if (height_q > HEIGHT_LIMIT) begin
			height_eff = HEIGHT_LIMIT;
		end else begin
			height_eff = height_q;
		end

		col_next  = EW'(col_q) + EW'(1);
		row_next  = CFG_W'(row_q) + CFG_W'(1);
		row_end   = (col_next >= width_eff);
		frame_end = (row_next >= height_eff);

		flags.has_left    = (col_q != '0);
		flags.has_up      = (row_q != '0);
		flags.has_upright = (row_q != '0) && !row_end;
		flags.last        = row_end && frame_end;
	end

	assign addr_up      = col_q;
	assign addr_upright = col_next[AW-1:0];

	// Advance the raster position on every taken pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_next[AW-1:0];
			end
		end
	end

endmodule

// ===== sv/nepc_accum.sv =====
// Compare stage, frame accumulator and output register.
// Depends on nepc_pkg and nepc_count_if.
module nepc_accum import nepc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [PIX_W-1:0] pixel,
	input  nepc_flags_t      flags,
	input  logic [PIX_W-1:0] rd_up,
	input  logic [PIX_W-1:0] rd_upright,
	output logic             take_ok,
	nepc_count_if.source     result
);

	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	nepc_flags_t      flags_s1;

	logic [PIX_W-1:0] left_q, upleft_q;
	logic [CNT_W-1:0] total_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] out_count_q;

	logic [PIX_W-1:0] left, upleft, up, upright;
	logic [ADD_W-1:0] add;
	logic [CNT_W-1:0] sum;
	logic             out_free, advance;

	always_comb begin
		left    = flags_s1.has_left ? left_q : '0;
		upleft  = (flags_s1.has_left && flags_s1.has_up) ? upleft_q : '0;
		up      = flags_s1.has_up ? rd_up : '0;
		upright = flags_s1.has_upright ? rd_upright : '0;

		// Each equal earlier neighbor counts twice: the pair is symmetric.
		if (pixel_s1 != '0) begin
			add = ADD_W'(1)
				+ {(ADD_W-1)'(left == pixel_s1), 1'b0}
				+ {(ADD_W-1)'(upleft == pixel_s1), 1'b0}
				+ {(ADD_W-1)'(up == pixel_s1), 1'b0}
				+ {(ADD_W-1)'(upright == pixel_s1), 1'b0};
		end else begin
			add = '0;
		end
		sum = total_q + CNT_W'(add);

		out_free = !out_valid_q || result.ready;
		advance  = valid_s1 && (!flags_s1.last || out_free);
		take_ok  = !valid_s1 || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pixel_s1 <= pixel;
			flags_s1 <= flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			upleft_q    <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && flags_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				left_q   <= pixel_s1;
				upleft_q <= up;
				total_q  <= flags_s1.last ? '0 : sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && flags_s1.last) begin
			out_count_q <= sum;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.match_count = out_count_q;

endmodule

// ===== sim/neighbor_equal_pixel_counter_tb.sv =====
// Self-checking bench for neighbor_equal_pixel_counter: streams raster frames, predicts each
// frame total in-line and compares every count the block returns, under varied stalls.
// Depends on nepc_pkg, the nepc_if channel interfaces and the block itself.
module neighbor_equal_pixel_counter_tb;
	import nepc_pkg::*;

	localparam int LINE_MAX      = 4096;       // widest row the line buffer holds
	localparam int SETTLE_CYCLES = 4;          // margin for the pipeline to empty
	localparam int RUN_LIMIT     = 2_400_000;  // hard stop, several times the slowest run
	localparam int PHASE_PIXELS  = 500;        // random pixels per stall profile

	// Register slots the block does not implement; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	// Frame content styles. Plain noise rarely makes equal neighbors, so most
	// styles draw from few values to keep the match logic busy.
	typedef enum int unsigned {
		FILL_NOISE,
		FILL_PALETTE,
		FILL_FLAT,
		FILL_RUNS
	} fill_t;

	logic clk = 1'b0;
	logic arst_n;

	nepc_cfg_if   cfg_bus ();
	nepc_pixel_if pix_bus ();
	nepc_count_if cnt_bus ();

	neighbor_equal_pixel_counter #(
		.MAX_WIDTH (LINE_MAX)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.pixels (pix_bus),
		.counts (cnt_bus)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the registers, the line buffer,
	// the raster position, the two window taps and the running total.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RESET;
	logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RESET;
	logic [PIX_W-1:0] line_store [LINE_MAX];
	int unsigned      col_pos    = 0;
	int unsigned      row_pos    = 0;
	logic [PIX_W-1:0] win_left   = '0;
	logic [PIX_W-1:0] win_upleft = '0;
	logic [CNT_W-1:0] frame_sum  = '0;

	logic [PIX_W-1:0] pixel_queue [$];  // requests not yet offered to the block
	logic [CNT_W-1:0] totals_due [$];   // frame totals still owed by the block

	bit          pix_taken;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int          mismatches = 0;

	// Zero means one; anything past the hardware limit saturates.
	function automatic int unsigned dim_limit(input logic [CFG_W-1:0] v, input int unsigned top);
		if (v == '0)
			return 1;
		return (v > top) ? top : int'(v);
	endfunction

	// Fold one pixel into the frame total. Equality is symmetric, so each
	// match against an earlier neighbor (left, up-left, up, up-right) counts
	// twice and the pixel itself once; neighbors off the image never match.
	function automatic void accumulate_pixel(input logic [PIX_W-1:0] p);
		int unsigned      w, h, c, r, add;
		logic [PIX_W-1:0] left, upleft, up, upright;
		w = dim_limit(width_reg, LINE_MAX);
		h = dim_limit(height_reg, int'(HEIGHT_LIMIT));
		c = col_pos;
		r = row_pos;
		left = '0;
		upleft = '0;
		up = '0;
		upright = '0;
		if (r > 0) begin
			up = line_store[c];
			if (c + 1 < w)
				upright = line_store[c + 1];
		end
		if (c > 0) begin
			left = win_left;
			if (r > 0)
				upleft = win_upleft;
		end
		if (p != '0) begin
			add = 1;
			if (left == p)    add += 2;
			if (upleft == p)  add += 2;
			if (up == p)      add += 2;
			if (upright == p) add += 2;
			frame_sum = CNT_W'(frame_sum + add);
		end
		win_upleft = up;
		win_left = p;
		line_store[c] = p;
		// A position at or past a shrunken row end closes the row here.
		if (c + 1 >= w) begin
			col_pos = 0;
			if (r + 1 >= h) begin
				totals_due = {totals_due, frame_sum};
				frame_sum = '0;
				row_pos = 0;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: sample every handshake at the rising edge. Track register
	// writes, predict on each accepted pixel, check each returned count.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic [CNT_W-1:0] want;
		pix_taken <= pix_bus.valid && pix_bus.ready;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					REG_FRAME_WIDTH: begin
						width_reg = cfg_bus.data;
					end
					REG_FRAME_HEIGHT: begin
						height_reg = cfg_bus.data;
					end
					default: begin
					end
				endcase
			end
			if (pix_bus.valid && pix_bus.ready)
				accumulate_pixel(pix_bus.pixel);
			if (cnt_bus.valid && cnt_bus.ready) begin
				if (totals_due.size() == 0) begin
					mismatches++;
					$error("match_count: expected none, actual %0d", cnt_bus.match_count);
				end else begin
					want = totals_due.pop_front();
					if (cnt_bus.match_count !== want) begin
						mismatches++;
						$error("match_count: expected %0d, actual %0d", want,
							cnt_bus.match_count);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: at the falling edge, hold a pending request until it is
	// taken, then either idle or offer the next pixel. The count ready
	// toggles at random with its own idle rate.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic go;
		if (!pix_bus.valid || pix_taken) begin
			go = arst_n && pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct;
			if (go)
				pix_bus.pixel <= pixel_queue.pop_front();
			pix_bus.valid <= go;
		end
		cnt_bus.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Drain: wait until every pixel is taken and every total returned, then
	// let the pipeline empty so a register write finds the block at rest.
	task automatic settle_stream();
		while (pixel_queue.size() != 0 || pix_bus.valid || totals_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Queue one full frame at the current effective size with a random style.
	task automatic push_frame();
		int unsigned      n;
		fill_t            mode;
		logic [PIX_W-1:0] a, b, px;
		n = dim_limit(width_reg, LINE_MAX) * dim_limit(height_reg, int'(HEIGHT_LIMIT));
		mode = fill_t'($urandom_range(3));
		a = PIX_W'($urandom_range(1, 255));
		b = PIX_W'($urandom_range(255));
		px = a;
		repeat (n) begin
			case (mode)
				FILL_NOISE: begin
					px = PIX_W'($urandom_range(255));
				end
				FILL_PALETTE: begin
					case ($urandom_range(2))
						0: px = '0;
						1: px = a;
						default: px = b;
					endcase
				end
				FILL_FLAT: begin
					px = ($urandom_range(9) == 0) ? '0 : a;
				end
				default: begin
					// Runs: mostly repeat the last value, now and then jump.
					if ($urandom_range(9) < 3)
						px = PIX_W'($urandom_range(255));
				end
			endcase
			pixel_queue = {pixel_queue, px};
		end
	endtask

	// Bring the block to rest, program both sizes, then queue whole frames.
	task automatic run_frames(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input int unsigned frames);
		settle_stream();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		repeat (frames) push_frame();
	endtask

	// Random sizes: mostly tiny frames so totals come back often, sometimes
	// wider or taller ones, and now and then a zero that must act as one.
	task automatic random_frames(input int unsigned quota);
		int unsigned      sent, frames;
		logic [CFG_W-1:0] w, h;
		sent = 0;
		while (sent < quota) begin
			case ($urandom_range(19))
				0: w = '0;
				1: w = CFG_W'($urandom_range(13, 64));
				default: w = CFG_W'($urandom_range(1, 12));
			endcase
			case ($urandom_range(19))
				0: h = '0;
				1: h = CFG_W'($urandom_range(9, 24));
				default: h = CFG_W'($urandom_range(1, 8));
			endcase
			frames = $urandom_range(1, 3);
			run_frames(w, h, frames);
			sent += frames * dim_limit(w, LINE_MAX) * dim_limit(h, int'(HEIGHT_LIMIT));
		end
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("neighbor_equal_pixel_counter test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		pix_bus.valid = 1'b0;
		pix_bus.pixel = '0;
		cnt_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		send_idle_pct = 26;
		recv_idle_pct = 85;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Reset sizes are live: start a 640-wide row, then shrink the width
		// mid-row. The column already sits past the new end, so the next
		// pixel closes the row; one more 3-pixel row then ends the frame.
		pixel_queue = {pixel_queue, 8'd255, 8'd255, 8'd1, 8'd0, 8'd255};
		settle_stream();
		write_reg(REG_FRAME_WIDTH, CFG_W'(3));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
		pixel_queue = {pixel_queue, 8'd9, 8'd255, 8'd255, 8'd1};

		// Shrink the height mid-frame below the current row: the frame must
		// end when that row ends.
		settle_stream();
		write_reg(REG_FRAME_WIDTH, CFG_W'(2));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(5));
		pixel_queue = {pixel_queue, 8'd7, 8'd7, 8'd7, 8'd7, 8'd128, 8'd128};
		settle_stream();
		write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
		pixel_queue = {pixel_queue, 8'd128, 8'd7};

		// Zero sizes act as one: every pixel is a frame. Writes to the unused
		// slots must not disturb either size.
		settle_stream();
		write_reg(REG_FRAME_WIDTH, '0);
		write_reg(REG_FRAME_HEIGHT, '0);
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '1);
		pixel_queue = {pixel_queue, 8'd0, 8'd255, 8'd1};

		// Full 3x3 of the top value: every neighbor matches.
		settle_stream();
		write_reg(REG_FRAME_WIDTH, CFG_W'(3));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
		repeat (9) pixel_queue = {pixel_queue, 8'd255};

		// Random frames under three stall profiles: slow sink, slow source,
		// then full rate on both sides.
		random_frames(PHASE_PIXELS);
		send_idle_pct = 85;
		recv_idle_pct = 26;
		random_frames(PHASE_PIXELS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_frames(PHASE_PIXELS);

		// Two frames back to back at full rate.
		run_frames(CFG_W'(5), CFG_W'(4), 2);

		settle_stream();
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("neighbor_equal_pixel_counter test passed");
		end else begin
			$display("neighbor_equal_pixel_counter test failed");
		end
		$finish;
	end

endmodule

// ===== neighbor_equal_pixel_counter.f =====
sv/nepc_pkg.sv
sv/nepc_if.sv
sv/nepc_line_mem.sv
sv/nepc_pos_ctrl.sv
sv/nepc_accum.sv
sv/neighbor_equal_pixel_counter.sv
sim/neighbor_equal_pixel_counter_tb.sv
